[src/lldq_pkg.sv]
// Shared codes and types for the least-loaded queue dispatcher.
package lldq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    localparam logic CFG_QUEUES_ONLINE = 1'b0;
    localparam logic CFG_LAUNCHED      = 1'b1;

    localparam int CFG_WIDTH = 4;
    localparam logic [CFG_WIDTH-1:0] QUEUES_ONLINE_RESET = 4'd8;

endpackage

[src/lldq_pick.sv]
// Queue choice for an add: next unused online queue, else least occupied.
module lldq_pick #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic [lldq_pkg::CFG_WIDTH-1:0]              queues_online,
    input  logic [$clog2(NUM_QUEUES+1)-1:0]             queues_in_use,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]            occupancy [NUM_QUEUES],
    output logic [$clog2(NUM_QUEUES+1)-1:0]             online_n,
    output logic [(NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1)-1:0] pick_q
);

    localparam int UW = $clog2(NUM_QUEUES + 1);
    localparam int QW = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [6:0]    online_wide;
    logic [QW-1:0] best;
    logic [CW-1:0] best_occ;

    always_comb
    begin
        online_wide = 7'(queues_online);
        if (online_wide == 7'd0)
        begin
            online_n = UW'(1);
        end
        else if (online_wide > 7'(NUM_QUEUES))
        begin
            online_n = UW'(NUM_QUEUES);
        end
        else
        begin
            online_n = online_wide[UW-1:0];
        end
    end

    // Ties go to the highest index, so a later equal count replaces the best.
    always_comb
    begin
        best     = '0;
        best_occ = occupancy[0];
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if ((UW'(i) < online_n) && (occupancy[i] <= best_occ))
            begin
                best     = QW'(i);
                best_occ = occupancy[i];
            end
        end
        if (queues_in_use < online_n)
        begin
            pick_q = queues_in_use[QW-1:0];
        end
        else
        begin
            pick_q = best;
        end
    end

endmodule

[src/least_loaded_multi_queue_dispatch.sv]
// Top level of the least-loaded dispatcher over per-worker thread id FIFOs.
//
// Input items carry a command (add, pop, peek), a thread id and a queue
// select, on a valid/ready channel. Each add, pop or peek gives one result
// item on the output valid/ready channel; the unused command is taken and
// dropped without a result. The user must write queues_online and launched
// through the configuration port while the block is idle; it is not enforced.
// An accepted item reads its queue entries from the queue store into
// registers as it is taken. In the execute state, once the output is empty
// or being taken, its result is registered along with the write-back of
// the entry and the queue counters, and only then is a new item taken.
// Reset clears the head pointers, the occupancy counters, the count of queues
// in use and the output valid; the queue store keeps its contents, as every
// read is gated by occupancy. When the receiver stalls, the waiting result
// holds, one more item may be accepted and then waits before write-back.
module least_loaded_multi_queue_dispatch #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_WIDTH    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [lldq_pkg::CFG_WIDTH-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [ID_WIDTH-1:0]               thread_id,
    input  logic [2:0]                        queue_sel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        queue_out,
    output logic [ID_WIDTH-1:0]               head_id,
    output logic [ID_WIDTH-1:0]               second_id,
    output logic                              has_second,
    output logic                              is_empty,
    output logic [1:0]                        status,
    output logic                              start_worker
);

    localparam int UW = $clog2(NUM_QUEUES + 1);
    localparam int QW = NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int SW = PW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [lldq_pkg::CFG_WIDTH-1:0] queues_online_reg;
    logic                           launched_reg;

    lldq_pkg::state_t state_reg, state_next;

    logic [PW-1:0] head_ptrs_reg [NUM_QUEUES];
    logic [CW-1:0] occupancy_reg [NUM_QUEUES];
    logic [UW-1:0] in_use_reg;

    logic [ID_WIDTH-1:0] store_mem [NUM_QUEUES][QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] rd_head_reg, rd_second_reg;

    lldq_pkg::cmd_t      cmd_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [QW-1:0]       q_reg;

    logic                out_valid_reg;
    logic [2:0]          queue_out_reg;
    logic [ID_WIDTH-1:0] head_id_reg, second_id_reg;
    logic                has_second_reg, is_empty_reg, start_worker_reg;
    lldq_pkg::status_t   status_reg;

    logic [UW-1:0] online_n;
    logic [QW-1:0] pick_q;
    logic [6:0]    sel_wrap;
    logic [QW-1:0] acc_q;
    logic [SW-1:0] acc_second_sum;
    logic [PW-1:0] acc_second_ptr;
    logic          accept, go;

    logic [CW-1:0]       cur_occ, occ_next;
    logic [PW-1:0]       cur_head, head_next;
    logic [SW-1:0]       slot_sum, head_sum;
    logic [PW-1:0]       wr_slot;
    logic                wr_en;
    logic [UW-1:0]       in_use_next;
    logic [ID_WIDTH-1:0] res_head, res_second;
    logic                res_start;
    lldq_pkg::status_t   res_status;
    logic [6:0]          q_wide;

    lldq_pick #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_pick (
        .queues_online (queues_online_reg),
        .queues_in_use (in_use_reg),
        .occupancy     (occupancy_reg),
        .online_n      (online_n),
        .pick_q        (pick_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queues_online_reg <= lldq_pkg::QUEUES_ONLINE_RESET;
            launched_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                lldq_pkg::CFG_QUEUES_ONLINE: queues_online_reg <= cfg_data;
                lldq_pkg::CFG_LAUNCHED:      launched_reg      <= cfg_data[0];
                default:                     launched_reg      <= launched_reg;
            endcase
        end
    end

    always_comb
    begin
        sel_wrap = 7'(queue_sel);
        for (int k = 0; k < 8; k++)
        begin
            if (sel_wrap >= 7'(NUM_QUEUES))
            begin
                sel_wrap = sel_wrap - 7'(NUM_QUEUES);
            end
        end
        if (lldq_pkg::cmd_t'(cmd) == lldq_pkg::CMD_ADD)
        begin
            acc_q = pick_q;
        end
        else
        begin
            acc_q = sel_wrap[QW-1:0];
        end
        acc_second_sum = SW'(head_ptrs_reg[acc_q]) + SW'(1);
        if (acc_second_sum >= DEPTH_S)
        begin
            acc_second_sum = acc_second_sum - DEPTH_S;
        end
        acc_second_ptr = acc_second_sum[PW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        go         = 1'b0;
        unique case (state_reg)
            lldq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (lldq_pkg::cmd_t'(cmd) != lldq_pkg::CMD_UNUSED))
                begin
                    state_next = lldq_pkg::ST_EXEC;
                end
            end
            lldq_pkg::ST_EXEC:
            begin
                go = !out_valid_reg || out_ready;
                if (go)
                begin
                    state_next = lldq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lldq_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lldq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= lldq_pkg::cmd_t'(cmd);
            id_reg  <= thread_id;
            q_reg   <= acc_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[q_reg][wr_slot] <= id_reg;
        end
        if (accept)
        begin
            rd_head_reg   <= store_mem[acc_q][head_ptrs_reg[acc_q]];
            rd_second_reg <= store_mem[acc_q][acc_second_ptr];
        end
    end

    always_comb
    begin
        cur_occ     = occupancy_reg[q_reg];
        cur_head    = head_ptrs_reg[q_reg];
        occ_next    = cur_occ;
        head_next   = cur_head;
        in_use_next = in_use_reg;
        wr_en       = 1'b0;
        res_head    = '0;
        res_second  = '0;
        res_start   = 1'b0;
        res_status  = lldq_pkg::STATUS_OK;

        slot_sum = SW'(cur_head) + SW'(cur_occ);
        if (slot_sum >= DEPTH_S)
        begin
            slot_sum = slot_sum - DEPTH_S;
        end
        wr_slot = slot_sum[PW-1:0];

        head_sum = SW'(cur_head) + SW'(1);
        if (head_sum >= DEPTH_S)
        begin
            head_sum = head_sum - DEPTH_S;
        end

        unique case (cmd_reg)
            lldq_pkg::CMD_ADD:
            begin
                if (cur_occ >= DEPTH_C)
                begin
                    res_status = lldq_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en    = go;
                    occ_next = cur_occ + CW'(1);
                    if (launched_reg)
                    begin
                        if (UW'(q_reg) == in_use_reg)
                        begin
                            in_use_next = in_use_reg + UW'(1);
                            res_start   = 1'b1;
                        end
                    end
                    else if (in_use_reg < online_n)
                    begin
                        in_use_next = in_use_reg + UW'(1);
                    end
                end
            end
            lldq_pkg::CMD_POP:
            begin
                if (cur_occ == '0)
                begin
                    res_status = lldq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    res_head  = rd_head_reg;
                    head_next = head_sum[PW-1:0];
                    occ_next  = cur_occ - CW'(1);
                end
            end
            lldq_pkg::CMD_PEEK:
            begin
                if (cur_occ >= CW'(1))
                begin
                    res_head = rd_head_reg;
                end
                if (cur_occ >= CW'(2))
                begin
                    res_second = rd_second_reg;
                end
            end
            default:
            begin
                res_status = lldq_pkg::STATUS_OK;
            end
        endcase
        q_wide = 7'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_ptrs_reg[i] <= '0;
                occupancy_reg[i] <= '0;
            end
            in_use_reg <= '0;
        end
        else if (go)
        begin
            head_ptrs_reg[q_reg] <= head_next;
            occupancy_reg[q_reg] <= occ_next;
            in_use_reg           <= in_use_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            queue_out_reg    <= q_wide[2:0];
            head_id_reg      <= res_head;
            second_id_reg    <= res_second;
            has_second_reg   <= occ_next >= CW'(2);
            is_empty_reg     <= occ_next == '0;
            status_reg       <= res_status;
            start_worker_reg <= res_start;
        end
    end

    assign out_valid    = out_valid_reg;
    assign queue_out    = queue_out_reg;
    assign head_id      = head_id_reg;
    assign second_id    = second_id_reg;
    assign has_second   = has_second_reg;
    assign is_empty     = is_empty_reg;
    assign status       = status_reg;
    assign start_worker = start_worker_reg;

endmodule
